// File: hw/rtl/mrfr_pkg.sv
package mrfr_pkg;

   localparam int FIELD_W       = 6;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;
   localparam int FIXED_FIELDS  = 4;
   localparam int COUNT_POS     = 6;

   localparam logic [7:0]  BROADCAST_ADDR  = 8'h00;
   localparam logic [7:0]  STATION_RESET   = 8'd247;
   localparam logic [7:0]  FUNC_READ_HOLD  = 8'h03;
   localparam logic [7:0]  FUNC_WRITE_ONE  = 8'h06;
   localparam logic [7:0]  FUNC_WRITE_MANY = 8'h10;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   // register index on the csr port
   localparam logic REG_STATION = 1'b0;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_FUNC   = 6'b000010,
      PH_FIXED  = 6'b000100,
      PH_MULTI  = 6'b001000,
      PH_CRC_LO = 6'b010000,
      PH_CRC_HI = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/mrfr_ram.sv
module mrfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/mrfr_ctrl.sv
module mrfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mrfr_pkg::dp_status_type status,
   output mrfr_pkg::dp_cmd_type    cmd
);

   import mrfr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = (state_ff == ST_IDLE);
      cmd.capture = req_valid && (state_ff == ST_IDLE);
      cmd.commit  = (state_ff == ST_EXEC) && status.out_free;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the output register can take a result
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_commit_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !req_ready)
      else $error("commit while ready for a new request");
`endif

endmodule

// File: hw/rtl/mrfr_datapath.sv
module mrfr_datapath #(
   parameter int MAX_FRAME = 64,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mrfr_pkg::dp_cmd_type          cmd,
   output mrfr_pkg::dp_status_type       status,
   input  logic [7:0]                    rx_byte,
   input  logic [7:0]                    station_address,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [7:0]                    ram_wdata,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [7:0]                    ram_rdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_frame_byte,
   output logic [mrfr_pkg::FIELD_W-1:0]  rsp_byte_index,
   output logic [mrfr_pkg::FIELD_W-1:0]  rsp_frame_length,
   output logic                          rsp_is_broadcast,
   output logic                          rsp_last_byte
);

   import mrfr_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [7:0]           byte_ff;
   logic [7:0]           fc_ff, fc_in;
   logic [CW-1:0]        bc_ff, bc_in;
   logic [15:0]          crc_ff, crc_in;
   logic [7:0]           crc_lo_ff, crc_lo_in;
   logic                 fbc_ff, fbc_in;
   logic                 drain_ff, drain_in;
   logic [FIELD_W-1:0]   dlen_ff, dlen_in;
   logic                 dbc_ff, dbc_in;
   logic [AW-1:0]        ep_ff, ep_in;
   logic                 ov_ff, ov_in;
   logic [7:0]           obyte_ff, obyte_in;
   logic [FIELD_W-1:0]   oidx_ff, oidx_in;
   logic [FIELD_W-1:0]   olen_ff, olen_in;
   logic                 obc_ff, obc_in;
   logic                 olast_ff, olast_in;

   logic                 out_load;
   logic                 put_ok;
   logic                 emit_last;
   logic [15:0]          crc_next;
   logic [7:0]           fc_dec;
   logic [FIELD_W-1:0]   new_len;
   logic                 new_last;

   assign put_ok    = bc_ff < CW'(MAX_FRAME);
   assign crc_next  = crc_add(crc_ff, byte_ff);
   assign emit_last = ({1'b0, FIELD_W'(ep_ff)} + 7'd1) >= {1'b0, dlen_ff};
   assign fc_dec    = (fc_ff != 8'd0) ? fc_ff - 8'd1 : fc_ff;
   assign new_len   = FIELD_W'(bc_ff - CW'(1));
   assign new_last  = new_len <= FIELD_W'(1);
   assign ram_raddr = drain_ff ? ep_ff : '0;
   assign ram_wdata = byte_ff;
   assign status.out_free = !ov_ff || rsp_ready;

   always_comb begin
      phase_in  = phase_ff;
      fc_in     = fc_ff;
      bc_in     = bc_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      fbc_in    = fbc_ff;
      drain_in  = drain_ff;
      dlen_in   = dlen_ff;
      dbc_in    = dbc_ff;
      ep_in     = ep_ff;
      ram_we    = 1'b0;
      ram_waddr = bc_ff[AW-1:0];
      out_load  = 1'b0;
      obyte_in  = ram_rdata;
      oidx_in   = FIELD_W'(ep_ff);
      olen_in   = dlen_ff;
      obc_in    = dbc_ff;
      olast_in  = emit_last;

      // advance the run in progress by one byte
      if (drain_ff) begin
         out_load = 1'b1;
         if (emit_last) begin
            drain_in = 1'b0;
         end else begin
            ep_in = ep_ff + AW'(1);
         end
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (byte_ff == station_address || byte_ff == BROADCAST_ADDR) begin
               ram_we    = 1'b1;
               ram_waddr = '0;
               bc_in     = CW'(1);
               crc_in    = crc_add(CRC_INIT, byte_ff);
               fbc_in    = (byte_ff == BROADCAST_ADDR);
               phase_in  = PH_FUNC;
            end
         end
         PH_FUNC: begin
            if ((byte_ff == FUNC_READ_HOLD || byte_ff == FUNC_WRITE_ONE ||
                 byte_ff == FUNC_WRITE_MANY) && put_ok) begin
               ram_we   = 1'b1;
               bc_in    = bc_ff + CW'(1);
               crc_in   = crc_next;
               fc_in    = 8'd0;
               phase_in = (byte_ff == FUNC_WRITE_MANY) ? PH_MULTI : PH_FIXED;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_FIXED: begin
            if (!put_ok) begin
               phase_in = PH_IDLE;
            end else begin
               ram_we = 1'b1;
               bc_in  = bc_ff + CW'(1);
               crc_in = crc_next;
               fc_in  = fc_ff + 8'd1;
               if (fc_ff >= 8'(FIXED_FIELDS - 1)) begin
                  phase_in = PH_CRC_LO;
               end
            end
         end
         PH_MULTI: begin
            if (!put_ok) begin
               phase_in = PH_IDLE;
            end else begin
               ram_we = 1'b1;
               bc_in  = bc_ff + CW'(1);
               crc_in = crc_next;
               if (bc_ff == CW'(COUNT_POS)) begin
                  // byte count field
                  fc_in = byte_ff;
                  if (byte_ff == 8'd0) begin
                     phase_in = PH_CRC_LO;
                  end
               end else if (bc_ff > CW'(COUNT_POS)) begin
                  fc_in = fc_dec;
                  if (fc_dec == 8'd0) begin
                     phase_in = PH_CRC_LO;
                  end
               end
            end
         end
         PH_CRC_LO: begin
            if (!put_ok) begin
               phase_in = PH_IDLE;
            end else begin
               ram_we    = 1'b1;
               bc_in     = bc_ff + CW'(1);
               crc_lo_in = byte_ff;
               phase_in  = PH_CRC_HI;
            end
         end
         PH_CRC_HI: begin
            phase_in = PH_IDLE;
            if (put_ok) begin
               ram_we = 1'b1;
               bc_in  = bc_ff + CW'(1);
               // start a run only when none is in progress; drop otherwise
               if ({byte_ff, crc_lo_ff} == crc_ff && !drain_ff) begin
                  out_load = 1'b1;
                  oidx_in  = '0;
                  olen_in  = new_len;
                  obc_in   = fbc_ff;
                  olast_in = new_last;
                  dlen_in  = new_len;
                  dbc_in   = fbc_ff;
                  drain_in = !new_last;
                  ep_in    = AW'(1);
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (!cmd.commit) begin
         ram_we = 1'b0;
      end
      ov_in = (ov_ff && !rsp_ready) || (cmd.commit && out_load);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= rx_byte;
      end
      if (cmd.commit) begin
         crc_lo_ff <= crc_lo_in;
         fbc_ff    <= fbc_in;
         dlen_ff   <= dlen_in;
         dbc_ff    <= dbc_in;
      end
      if (cmd.commit && out_load) begin
         obyte_ff <= obyte_in;
         oidx_ff  <= oidx_in;
         olen_ff  <= olen_in;
         obc_ff   <= obc_in;
         olast_ff <= olast_in;
      end
      if (reset) begin
         phase_ff <= PH_IDLE;
         fc_ff    <= '0;
         bc_ff    <= '0;
         crc_ff   <= CRC_INIT;
         drain_ff <= 1'b0;
         ep_ff    <= '0;
         ov_ff    <= 1'b0;
      end else begin
         if (cmd.commit) begin
            phase_ff <= phase_in;
            fc_ff    <= fc_in;
            bc_ff    <= bc_in;
            crc_ff   <= crc_in;
            drain_ff <= drain_in;
            ep_ff    <= ep_in;
         end
         ov_ff <= ov_in;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_frame_byte   = obyte_ff;
   assign rsp_byte_index   = oidx_ff;
   assign rsp_frame_length = olen_ff;
   assign rsp_is_broadcast = obc_ff;
   assign rsp_last_byte    = olast_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bc_ff <= CW'(MAX_FRAME))
      else $error("frame byte count beyond buffer");
   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> ({1'b0, FIELD_W'(ep_ff)} < {1'b0, dlen_ff}))
      else $error("emit pointer past end of run");
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && olast_ff) |-> ({1'b0, oidx_ff} + 7'd1 == {1'b0, olen_ff}))
      else $error("last byte not at end of frame");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && out_load) |=> ov_ff)
      else $error("result lost at commit");
`endif

endmodule

// File: hw/rtl/modbus_rtu_frame_receiver_top.sv
// Each request is taken in two steps: one captures the byte while the frame buffer
// RAM reads the next byte of the run, one updates the parser and CRC and writes the
// buffer. A new request is taken only after the previous update; the result is loaded
// into the output register with the update, and an untaken result holds the update of
// the next request. Synchronous reset returns the parser to idle, ends any run and
// sets the station address to 247; the frame buffer is not cleared.
module modbus_rtu_frame_receiver_top #(
   parameter int MAX_FRAME = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_frame_byte,
   output logic [mrfr_pkg::FIELD_W-1:0]   rsp_byte_index,
   output logic [mrfr_pkg::FIELD_W-1:0]   rsp_frame_length,
   output logic                           rsp_is_broadcast,
   output logic                           rsp_last_byte,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mrfr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [mrfr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [mrfr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);

   import mrfr_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [7:0]    station_ff, station_in;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;
   logic          reg_sel;

   assign reg_sel    = (csr_paddr[2] == REG_STATION);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? {(CSR_DW - 8)'(0), station_ff} : '0;

   always_comb begin
      station_in = station_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         station_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= STATION_RESET;
      end else begin
         station_ff <= station_in;
      end
   end

   mrfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrfr_datapath #(
      .MAX_FRAME (MAX_FRAME),
      .AW        (AW),
      .CW        (CW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .rx_byte          (req_rx_byte),
      .station_address  (station_ff),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_is_broadcast (rsp_is_broadcast),
      .rsp_last_byte    (rsp_last_byte)
   );

   mrfr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// File: tb/sv/tb_modbus_rtu_frame_receiver_top.sv
module tb_modbus_rtu_frame_receiver_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mrfr_pkg::*;

   localparam int MAX_FRAME   = 64;
   localparam int PHASE_ITEMS = 560;
   localparam int SETTLE_CYC  = 20;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [CSR_AW-1:0] STATION_OFS = CSR_AW'(4 * REG_STATION);

   typedef struct {
      logic [7:0]         data;
      logic [FIELD_W-1:0] index;
      logic [FIELD_W-1:0] length;
      logic               bcast;
      logic               last;
   } frame_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [7:0]          rsp_frame_byte;
   logic [FIELD_W-1:0]  rsp_byte_index;
   logic [FIELD_W-1:0]  rsp_frame_length;
   logic                rsp_is_broadcast;
   logic                rsp_last_byte;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // requests waiting to be driven, and frame bytes the receiver still owes
   logic [7:0]          rx_backlog [$];
   frame_beat_type      due_frame_bytes [$];

   int unsigned         sent_total = 0;
   int unsigned         taken_total = 0;
   int unsigned         error_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         send_idle_pct = 33;
   int unsigned         recv_idle_pct = 67;

   // shadow of the receiver state
   logic [7:0]          station_reg = STATION_RESET;
   phase_type           rx_phase = PH_IDLE;
   logic [7:0]          fld_cnt = 8'h00;
   logic [6:0]          stored_cnt = 7'd0;
   logic [7:0]          frame_mem [MAX_FRAME];
   logic [15:0]         crc_acc = CRC_INIT;
   logic [5:0]          out_ptr = 6'd0;
   logic                run_active = 1'b0;
   logic [6:0]          run_len = 7'd0;
   logic                run_bcast = 1'b0;

   modbus_rtu_frame_receiver_top #(
      .MAX_FRAME(MAX_FRAME)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_is_broadcast (rsp_is_broadcast),
      .rsp_last_byte    (rsp_last_byte),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   // store one frame byte; drop the frame when the buffer is full
   function automatic bit store_byte(input logic [7:0] b);
      if (stored_cnt >= MAX_FRAME) begin
         rx_phase = PH_IDLE;
         return 1'b0;
      end
      frame_mem[stored_cnt[5:0]] = b;
      stored_cnt++;
      return 1'b1;
   endfunction

   function automatic void emit_frame_byte();
      frame_beat_type beat;
      beat.data   = frame_mem[out_ptr];
      beat.index  = out_ptr;
      beat.length = run_len[5:0];
      beat.bcast  = run_bcast;
      beat.last   = (int'(out_ptr) + 1 >= int'(run_len));
      due_frame_bytes.push_back(beat);
      if (beat.last) begin
         run_active = 1'b0;
      end else begin
         out_ptr++;
      end
   endfunction

   function automatic void absorb_rx_byte(input logic [7:0] b);
      logic        was_busy;
      logic [6:0]  pos;
      logic [15:0] rx_crc;
      was_busy = run_active;
      if (run_active) begin
         emit_frame_byte();
      end
      case (rx_phase)
         PH_IDLE: begin
            if (b == station_reg || b == BROADCAST_ADDR) begin
               stored_cnt = 7'd0;
               crc_acc = CRC_INIT;
               if (store_byte(b)) begin
                  crc_acc = crc16_step(crc_acc, b);
                  rx_phase = PH_FUNC;
               end
            end
         end
         PH_FUNC: begin
            if (b == FUNC_READ_HOLD || b == FUNC_WRITE_ONE || b == FUNC_WRITE_MANY) begin
               if (store_byte(b)) begin
                  crc_acc = crc16_step(crc_acc, b);
                  rx_phase = (b == FUNC_WRITE_MANY) ? PH_MULTI : PH_FIXED;
                  fld_cnt = 8'h00;
               end
            end else begin
               rx_phase = PH_IDLE;
            end
         end
         PH_FIXED: begin
            if (store_byte(b)) begin
               crc_acc = crc16_step(crc_acc, b);
               fld_cnt++;
               if (fld_cnt >= FIXED_FIELDS) rx_phase = PH_CRC_LO;
            end
         end
         PH_MULTI: begin
            pos = stored_cnt;
            if (store_byte(b)) begin
               crc_acc = crc16_step(crc_acc, b);
               if (pos == COUNT_POS) begin
                  fld_cnt = b;
                  if (b == 8'h00) rx_phase = PH_CRC_LO;
               end else if (pos > COUNT_POS) begin
                  if (fld_cnt > 0) fld_cnt--;
                  if (fld_cnt == 0) rx_phase = PH_CRC_LO;
               end
            end
         end
         PH_CRC_LO: begin
            if (store_byte(b)) rx_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            if (store_byte(b)) begin
               rx_phase = PH_IDLE;
               rx_crc = {b, frame_mem[stored_cnt[5:0] - 6'd2]};
               // a frame completing while the previous one still drains is lost
               if (rx_crc == crc_acc && !was_busy) begin
                  run_len    = stored_cnt - 7'd2;
                  run_bcast  = (frame_mem[0] == BROADCAST_ADDR);
                  out_ptr    = 6'd0;
                  run_active = 1'b1;
                  emit_frame_byte();
               end
            end
         end
         default: rx_phase = PH_IDLE;
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin : drive_proc
      logic       take;
      logic       nxt_valid;
      logic [7:0] nxt_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_ready;
         if (take) begin
            absorb_rx_byte(req_rx_byte);
            taken_total++;
         end
         nxt_valid = req_valid && !take;
         nxt_byte  = req_rx_byte;
         if (!nxt_valid && rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt_valid = 1'b1;
            nxt_byte  = rx_backlog.pop_front();
         end
         req_valid   <= nxt_valid;
         req_rx_byte <= nxt_byte;
      end
   end

   always @(posedge clock) begin : check_proc
      frame_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_frame_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected frame byte, expected none actual %0h",
                        $time, rsp_frame_byte);
            end else begin
               want = due_frame_bytes.pop_front();
               check_field("frame_byte", want.data, rsp_frame_byte);
               check_field("byte_index", want.index, rsp_byte_index);
               check_field("frame_length", want.length, rsp_frame_length);
               check_field("is_broadcast", want.bcast, rsp_is_broadcast);
               check_field("last_byte", want.last, rsp_last_byte);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modbus_rtu_frame_receiver_top test failed");
         $finish;
      end
   end

   task automatic push_rx(input logic [7:0] b);
      rx_backlog.push_back(b);
      sent_total++;
   endtask

   function automatic logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // build a request with a correct or corrupted CRC, optionally cut short
   task automatic queue_request(input logic [7:0] addr, input logic [7:0] func,
                                input int count, input int cut, input bit bad_crc);
      logic [7:0]  fb [$];
      logic [15:0] crc;
      bit          known;
      fb = {addr, func};
      known = (func == FUNC_READ_HOLD || func == FUNC_WRITE_ONE || func == FUNC_WRITE_MANY);
      if (known) begin
         for (int i = 0; i < FIXED_FIELDS; i++) fb.push_back(pick_byte());
      end
      if (func == FUNC_WRITE_MANY) begin
         fb.push_back(8'(count));
         for (int i = 0; i < count; i++) fb.push_back(pick_byte());
      end
      if (known) begin
         crc = CRC_INIT;
         foreach (fb[i]) crc = crc16_step(crc, fb[i]);
         if (bad_crc) crc ^= 16'($urandom_range(1, 65535));
         fb.push_back(crc[7:0]);
         fb.push_back(crc[15:8]);
      end
      for (int i = 0; i < cut && fb.size() > 1; i++) void'(fb.pop_back());
      foreach (fb[i]) push_rx(fb[i]);
   endtask

   task automatic random_request();
      int unsigned pick;
      int unsigned r;
      int          cnt;
      logic [7:0]  addr;
      logic [7:0]  other;
      bit          bad;
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 4) == 0) ? BROADCAST_ADDR : station_reg;
      bad  = ($urandom_range(0, 11) == 0);
      if (pick < 45) begin
         queue_request(addr, $urandom_range(0, 1) ? FUNC_READ_HOLD : FUNC_WRITE_ONE, 0, 0, bad);
      end else if (pick < 70) begin
         r = $urandom_range(0, 99);
         if (r < 65) cnt = $urandom_range(0, 6);
         else if (r < 88) cnt = $urandom_range(7, 20);
         else if (r < 96) cnt = MAX_FRAME - 9;
         else cnt = $urandom_range(MAX_FRAME - 8, MAX_FRAME + 6);
         queue_request(addr, FUNC_WRITE_MANY, cnt, 0, bad);
      end else if (pick < 78) begin
         do other = 8'($urandom_range(0, 255));
         while (other == FUNC_READ_HOLD || other == FUNC_WRITE_ONE || other == FUNC_WRITE_MANY);
         queue_request(addr, other, 0, 0, 1'b0);
      end else if (pick < 85) begin
         do other = 8'($urandom_range(1, 255));
         while (other == station_reg);
         queue_request(other, FUNC_READ_HOLD, 0, 0, 1'b0);
      end else if (pick < 93) begin
         queue_request(addr, $urandom_range(0, 1) ? FUNC_WRITE_ONE : FUNC_WRITE_MANY,
                       $urandom_range(0, 6), $urandom_range(1, 4), 1'b0);
      end else begin
         r = $urandom_range(1, 3);
         for (int i = 0; i < r; i++) push_rx(8'($urandom_range(0, 255)));
      end
   endtask

   // hold until every request is taken and every frame byte has arrived
   task automatic wait_drained();
      while (taken_total != sent_total || due_frame_bytes.size() != 0) begin
         // a run advances one byte per request: feed bytes that match no address
         if (taken_total == sent_total && rx_backlog.size() == 0) push_rx(8'hFF);
         @(posedge clock);
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input logic [7:0] wval, output logic [7:0] rval);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= STATION_OFS;
      csr_pwdata  <= {24'h000000, wval};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      rval = csr_prdata[7:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_station(input logic [7:0] addr);
      logic [7:0] rd;
      csr_transfer(1'b1, addr, rd);
      station_reg = addr;
      csr_transfer(1'b0, 8'h00, rd);
      check_field("station_address", addr, rd);
   endtask

   task automatic run_random_phase();
      int unsigned start;
      start = sent_total;
      while (sent_total - start < PHASE_ITEMS) random_request();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset address, zero byte count broadcast, bad CRC, unknown code, foreign byte
      queue_request(STATION_RESET, FUNC_READ_HOLD, 0, 0, 1'b0);
      queue_request(BROADCAST_ADDR, FUNC_WRITE_MANY, 0, 0, 1'b0);
      queue_request(STATION_RESET, FUNC_WRITE_ONE, 0, 0, 1'b1);
      queue_request(STATION_RESET, 8'h01, 0, 0, 1'b0);
      push_rx(8'h05);
      wait_drained();

      set_station(8'd1);
      // longest frame, a short one lost while it drains, then an oversized one
      queue_request(8'd1, FUNC_WRITE_MANY, MAX_FRAME - 9, 0, 1'b0);
      queue_request(8'd1, FUNC_READ_HOLD, 0, 0, 1'b0);
      queue_request(BROADCAST_ADDR, FUNC_WRITE_MANY, MAX_FRAME - 8, 0, 1'b0);
      run_random_phase();
      wait_drained();

      send_idle_pct = 67;
      recv_idle_pct = 33;
      set_station(STATION_RESET);
      run_random_phase();
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_station(8'($urandom_range(2, 246)));
      run_random_phase();
      wait_drained();

      if (error_count == 0) begin
         $display("modbus_rtu_frame_receiver_top test passed");
      end else begin
         $display("modbus_rtu_frame_receiver_top test failed");
      end
      $finish;
   end

endmodule
